/* hw/rtl/ccst_pkg.sv */
// ============================================================================
// Collatz coefficient survival test package
// Widths, reset values and the stopping threshold function shared by the design.
// ============================================================================
package ccst_pkg;

    localparam int CANDIDATE_WIDTH     = 64;
    localparam int STEP_LIMIT_WIDTH    = 7;
    localparam int COUNT_OUT_WIDTH     = 7;
    localparam int M_TDATA_WIDTH       = 16;
    localparam int MAX_STEPS_DEFAULT   = 64;
    localparam int VALUE_WIDTH_DEFAULT = 104;
    localparam int TAB_WIDTH           = 264;

    localparam logic [STEP_LIMIT_WIDTH-1:0] STEP_LIMIT_RESET = STEP_LIMIT_WIDTH'(64);

    // Least a with 3^a >= 2^j, evaluated at elaboration time.
    function automatic int ccst_threshold(input int j);
        logic [TAB_WIDTH-1:0] p2;
        logic [TAB_WIDTH-1:0] p3;
        int                   a;
        p2 = TAB_WIDTH'(1);
        p3 = TAB_WIDTH'(1);
        a  = 0;
        for (int i = 1; i <= j; i++) begin
            p2 = p2 << 1;
            while (p3 < p2) begin
                p3 = p3 + (p3 << 1);
                a  = a + 1;
            end
        end
        return a;
    endfunction

endpackage

/* hw/rtl/collatz_coefficient_survival_test_unit.sv */
// ============================================================================
// Collatz coefficient survival test unit
// Runs each candidate through accelerated Collatz steps and reports whether
// the odd-step count keeps up with the contraction threshold.
// ============================================================================
// The unit takes one candidate per clock while the result side is not stalled
// and returns one result per candidate, in order. Each accelerated step has
// its own pipeline stage holding a VALUE_WIDTH-bit orbit value, so the stage
// count sets the latency and one wide add per stage sets the clock.
// A candidate that fails early rides the remaining stages unchanged.
// Back-pressure on the result side stalls the whole pipeline. The step limit
// saturates at MAX_STEPS, resets to 64 and is written through cfg_wr_en and
// cfg_wr_data, by the user only while empty; the unit does not enforce this.
module collatz_coefficient_survival_test_unit #(
    parameter int MAX_STEPS   = ccst_pkg::MAX_STEPS_DEFAULT,
    parameter int VALUE_WIDTH = ccst_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [ccst_pkg::STEP_LIMIT_WIDTH-1:0]  cfg_wr_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // candidate
    input  logic [ccst_pkg::CANDIDATE_WIDTH-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // survives, fail_step, odd_count, zero padding
    output logic [ccst_pkg::M_TDATA_WIDTH-1:0]     m_axis_tdata
);

    import ccst_pkg::*;

    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int CMP_W = (CNT_W > STEP_LIMIT_WIDTH) ? CNT_W : STEP_LIMIT_WIDTH;

    logic [STEP_LIMIT_WIDTH-1:0] step_limit_reg;
    logic                        adv;

    logic [VALUE_WIDTH-1:0] value_reg  [1:MAX_STEPS];
    logic [VALUE_WIDTH-1:0] value_next [1:MAX_STEPS];
    logic [CNT_W-1:0]       odd_reg    [1:MAX_STEPS];
    logic [CNT_W-1:0]       odd_next   [1:MAX_STEPS];
    logic [CNT_W-1:0]       fail_reg   [1:MAX_STEPS];
    logic [CNT_W-1:0]       fail_next  [1:MAX_STEPS];
    logic                   failed_reg [1:MAX_STEPS];
    logic                   failed_next[1:MAX_STEPS];
    logic                   valid_reg  [1:MAX_STEPS];
    logic                   valid_next [1:MAX_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_limit_reg <= STEP_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            step_limit_reg <= cfg_wr_data;
        end
    end

    assign adv           = !valid_reg[MAX_STEPS] || m_axis_tready;
    assign s_axis_tready = adv;

    for (genvar k = 1; k <= MAX_STEPS; k++) begin : g_stage
        logic [VALUE_WIDTH-1:0] v_in;
        logic [CNT_W-1:0]       q_in;
        logic [CNT_W-1:0]       f_in;
        logic                   failed_in;
        logic [VALUE_WIDTH+1:0] tripled;
        logic [VALUE_WIDTH+1:0] stepped;
        logic [CNT_W-1:0]       q_step;
        logic                   active;

        if (k == 1) begin : g_first
            assign v_in       = VALUE_WIDTH'(s_axis_tdata);
            assign q_in       = '0;
            assign f_in       = '0;
            assign failed_in  = 1'b0;
            assign valid_next[k] = s_axis_tvalid;
        end else begin : g_rest
            assign v_in       = value_reg[k-1];
            assign q_in       = odd_reg[k-1];
            assign f_in       = fail_reg[k-1];
            assign failed_in  = failed_reg[k-1];
            assign valid_next[k] = valid_reg[k-1];
        end

        assign active  = !failed_in && (CMP_W'(k) <= CMP_W'(step_limit_reg));
        assign tripled = {2'b00, v_in} + {1'b0, v_in, 1'b1};
        assign stepped = v_in[0] ? tripled : {2'b00, v_in};
        assign q_step  = q_in + CNT_W'(v_in[0]);

        always_comb begin
            value_next[k]  = v_in;
            odd_next[k]    = q_in;
            fail_next[k]   = f_in;
            failed_next[k] = failed_in;
            if (active) begin
                value_next[k] = stepped[VALUE_WIDTH:1];
                odd_next[k]   = q_step;
                if (q_step < CNT_W'(ccst_threshold(k))) begin
                    fail_next[k]   = CNT_W'(k);
                    failed_next[k] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= valid_next[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                value_reg[k]  <= value_next[k];
                odd_reg[k]    <= odd_next[k];
                fail_reg[k]   <= fail_next[k];
                failed_reg[k] <= failed_next[k];
            end
        end
    end

    assign m_axis_tvalid = valid_reg[MAX_STEPS];
    assign m_axis_tdata  = {1'b0,
                            COUNT_OUT_WIDTH'(odd_reg[MAX_STEPS]),
                            COUNT_OUT_WIDTH'(fail_reg[MAX_STEPS]),
                            !failed_reg[MAX_STEPS]};

endmodule

/* tb/collatz_coefficient_survival_test_unit_tb.sv */
// ============================================================================
// Collatz coefficient survival test unit testbench
// Streams directed and random candidates through the unit under several step
// limits and idle patterns, predicts each result with an independent model of
// the accelerated Collatz orbit and compares every result transfer in order.
// ============================================================================
module collatz_coefficient_survival_test_unit_tb;

    import ccst_pkg::*;

    localparam int MAX_STEPS     = MAX_STEPS_DEFAULT;
    localparam int VALUE_WIDTH   = VALUE_WIDTH_DEFAULT;
    localparam int DRAIN_CYCLES  = MAX_STEPS + 24;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [COUNT_OUT_WIDTH-1:0] odd_count;
        logic [COUNT_OUT_WIDTH-1:0] fail_step;
        logic                       survives;
    } verdict_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [STEP_LIMIT_WIDTH-1:0]   cfg_wr_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [CANDIDATE_WIDTH-1:0]    s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0]      m_axis_tdata;

    logic [CANDIDATE_WIDTH-1:0]    pending_candidates[$];
    verdict_t                      expected_verdicts[$];
    int                            min_odd_steps[0:MAX_STEPS];
    logic [STEP_LIMIT_WIDTH-1:0]   step_limit_shadow = STEP_LIMIT_RESET;
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;
    int                            candidates_sent = 0;
    int                            verdicts_checked = 0;
    int                            survivors_seen = 0;
    int                            mismatches = 0;
    int                            limits_tried = 1;
    int                            quiet_cycles = 0;

    collatz_coefficient_survival_test_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        logic [127:0] pow2;
        logic [127:0] pow3;
        int           a;
        pow2 = 128'd1;
        pow3 = 128'd1;
        a = 0;
        min_odd_steps[0] = 0;
        for (int j = 1; j <= MAX_STEPS; j++) begin
            pow2 = pow2 << 1;
            while (pow3 < pow2) begin
                pow3 = pow3 * 3;
                a++;
            end
            min_odd_steps[j] = a;
        end
    end

    function automatic verdict_t predict_verdict(input logic [CANDIDATE_WIDTH-1:0] n,
                                                 input logic [STEP_LIMIT_WIDTH-1:0] lim_reg);
        logic [VALUE_WIDTH+1:0] orbit;
        verdict_t               v;
        int                     lim;
        int                     odd;
        int                     fail;
        lim = (lim_reg > MAX_STEPS) ? MAX_STEPS : int'(lim_reg);
        orbit = '0;
        orbit[CANDIDATE_WIDTH-1:0] = n;
        odd = 0;
        fail = 0;
        for (int step = 1; step <= lim && fail == 0; step++) begin
            if (orbit[0]) begin
                orbit = orbit * 3 + 1;
                odd++;
            end
            orbit = orbit >> 1;
            orbit[VALUE_WIDTH+1:VALUE_WIDTH] = 2'b00;
            if (odd < min_odd_steps[step]) begin
                fail = step;
            end
        end
        v.survives  = (fail == 0);
        v.fail_step = fail[COUNT_OUT_WIDTH-1:0];
        v.odd_count = odd[COUNT_OUT_WIDTH-1:0];
        return v;
    endfunction

    // Random candidates, four times in ten with the low bits forced to all ones, since those survive many steps.
    function automatic logic [CANDIDATE_WIDTH-1:0] draw_candidate();
        logic [CANDIDATE_WIDTH-1:0] c;
        int                         k;
        c = {$urandom, $urandom};
        k = $urandom_range(1, 63);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                c = c | ((64'd1 << k) - 64'd1);
            end
            4, 5: begin
            end
            6: begin
                c[0] = 1'b1;
            end
            7: begin
                c = 64'($urandom_range(0, 4095));
            end
            8: begin
                c = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 255));
            end
            default: begin
                c = (64'd1 << k) + 64'($urandom_range(0, 3)) - 64'd1;
            end
        endcase
        return c;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_verdicts.push_back(predict_verdict(s_axis_tdata, step_limit_shadow));
                candidates_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_candidates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_candidates.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got = verdict_t'(m_axis_tdata[$bits(verdict_t)-1:0]);
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Unexpected result transfer: survives %0d fail_step %0d odd_count %0d",
                                 got.survives, got.fail_step, got.odd_count);
                    end
                end else begin
                    want = expected_verdicts.pop_front();
                    verdicts_checked++;
                    if (want.survives) begin
                        survivors_seen++;
                    end
                    if (got.survives !== want.survives || got.fail_step !== want.fail_step ||
                        got.odd_count !== want.odd_count) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("Result %0d mismatch: survives %0d/%0d fail_step %0d/%0d odd_count %0d/%0d (expected/actual)",
                                     verdicts_checked, want.survives, got.survives, want.fail_step,
                                     got.fail_step, want.odd_count, got.odd_count);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout with %0d results outstanding.", expected_verdicts.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_candidates.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [STEP_LIMIT_WIDTH-1:0] lim, input int send_pct,
                             input int recv_pct, input int count);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        step_limit_shadow = lim;
        limits_tried++;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            pending_candidates.push_back(draw_candidate());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed candidates at the reset step limit: zero, even values, the
        // field extremes and long-surviving odd values.
        pending_candidates = {64'd0, 64'd1, 64'd2, 64'd3, 64'd7, 64'd27, 64'd31, 64'd255,
                              64'd703, 64'd77671, 64'd63728127, 64'hFFFF_FFFF,
                              64'h1_0000_0001, 64'hFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                              64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                              64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                              64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_FFFF};

        run_phase(7'd0,   0,  0,  30);
        run_phase(7'd1,   63, 0,  40);
        run_phase(7'd127, 63, 0,  60);
        run_phase(7'd65,  0,  63, 50);
        run_phase(7'd64,  0,  63, 130);
        run_phase(7'd10,  29, 29, 60);
        run_phase(7'd40,  0,  0,  70);
        run_phase(7'($urandom_range(2, 63)), 29, 29, 90);
        wait_idle();

        if (expected_verdicts.size() != 0) begin
            mismatches++;
        end
        $display("Checked %0d results for %0d candidates over %0d step limit settings.",
                 verdicts_checked, candidates_sent, limits_tried);
        $display("Survivors: %0d, early failures: %0d, mismatches: %0d.",
                 survivors_seen, verdicts_checked - survivors_seen, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
